// ===== design/clp_pkg.sv =====
package clp_pkg;

    // configuration port
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 64;

    // register index, taken from paddr bit 3 (registers lie 8 bytes apart)
    localparam logic REG_DEVICE_IDENT        = 1'b0;
    localparam logic REG_DEVICE_IDENT_LENGTH = 1'b1;

    typedef struct packed {
        logic [63:0] device_ident;
        logic [3:0]  device_ident_length;
    } cfg_t;

    typedef enum logic [1:0] {
        ACT_REBOOT  = 2'd0,
        ACT_RESET   = 2'd1,
        ACT_TRIP    = 2'd2,
        ACT_UNKNOWN = 2'd3
    } action_t;

    // field stage of the current line
    typedef enum logic [3:0] {
        STAGE_PREFIX  = 4'b0001,
        STAGE_IDENT   = 4'b0010,
        STAGE_COMMAND = 4'b0100,
        STAGE_REJECT  = 4'b1000
    } stage_t;

    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] PRINTABLE_LO  = 8'd32;
    localparam logic [7:0] PRINTABLE_HI  = 8'd126;

    localparam int unsigned PREFIX_LEN = 4;
    localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h43, 8'h4D, 8'h44, 8'h3A};

    localparam int unsigned NUM_WORDS    = 3;
    localparam int unsigned WORD_MAX_LEN = 6;

    // REBOOT, RESET, TRIP; unused tail characters are zero
    localparam logic [7:0] WORD_TEXT [NUM_WORDS][WORD_MAX_LEN] = '{
        '{8'h52, 8'h45, 8'h42, 8'h4F, 8'h4F, 8'h54},
        '{8'h52, 8'h45, 8'h53, 8'h45, 8'h54, 8'h00},
        '{8'h54, 8'h52, 8'h49, 8'h50, 8'h00, 8'h00}
    };
    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{3'd6, 3'd5, 3'd4};

endpackage

// ===== design/clp_rx_if.sv =====
interface clp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/clp_act_if.sv =====
interface clp_act_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;

    modport source (output valid, output action, input ready);
    modport sink (input valid, input action, output ready);
endinterface

// ===== design/clp_cfg_regs.sv =====
module clp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [clp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [clp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output clp_pkg::cfg_t                     cfg
);
    import clp_pkg::*;

    logic [63:0] device_ident_reg;
    logic [3:0]  device_ident_length_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_ident_reg        <= '0;
            device_ident_length_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DEVICE_IDENT:        device_ident_reg        <= pwdata[63:0];
                REG_DEVICE_IDENT_LENGTH: device_ident_length_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DEVICE_IDENT:        prdata = device_ident_reg;
            REG_DEVICE_IDENT_LENGTH: prdata = {60'd0, device_ident_length_reg};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.device_ident        = device_ident_reg;
    assign cfg.device_ident_length = device_ident_length_reg;
endmodule

// ===== design/clp_line_step.sv =====
module clp_line_step #(
    parameter int unsigned LINE_CAPACITY = 64,
    parameter int unsigned IDENT_CHARS   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    input  clp_pkg::cfg_t     cfg,
    output logic              emit,
    output clp_pkg::action_t  action
);
    import clp_pkg::*;

    localparam int unsigned POS_W = $clog2(LINE_CAPACITY);
    localparam int unsigned CMP_W = (POS_W > 4) ? POS_W : 4;

    logic [POS_W-1:0] line_length_reg, line_length_next;
    logic [POS_W-1:0] field_position_reg, field_position_next;
    stage_t           field_stage_reg, field_stage_next;
    logic             ident_ok_reg, ident_ok_next;
    logic [2:0]       candidates_reg, candidates_next;

    logic             terminate;
    logic             printable;
    logic [3:0]       ident_len;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] ident_len_ext;
    logic [7:0]       ident_char;
    logic             word_hit;

    assign terminate = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR) ||
                       (line_length_reg >= POS_W'(LINE_CAPACITY - 1));
    assign printable = (rx_byte >= PRINTABLE_LO) && (rx_byte <= PRINTABLE_HI);

    // lengths above the identifier width count as the full width
    assign ident_len     = (cfg.device_ident_length > 4'(IDENT_CHARS)) ?
                           4'(IDENT_CHARS) : cfg.device_ident_length;
    assign pos_ext       = CMP_W'(field_position_reg);
    assign ident_len_ext = CMP_W'(ident_len);
    assign ident_char    = cfg.device_ident[{field_position_reg[2:0], 3'b000} +: 8];

    assign emit = terminate && (line_length_reg != '0) &&
                  (field_stage_reg == STAGE_COMMAND) && ident_ok_reg;

    // first word that still matches and is complete
    always_comb
    begin
        action   = ACT_UNKNOWN;
        word_hit = 1'b0;
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            if (!word_hit && candidates_reg[k] &&
                (pos_ext == CMP_W'(WORD_LEN[k])))
            begin
                action   = action_t'(2'(k));
                word_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        line_length_next    = line_length_reg;
        field_position_next = field_position_reg;
        field_stage_next    = field_stage_reg;
        ident_ok_next       = ident_ok_reg;
        candidates_next     = candidates_reg;

        if (terminate)
        begin
            line_length_next    = '0;
            field_position_next = '0;
            field_stage_next    = STAGE_PREFIX;
            ident_ok_next       = 1'b1;
            candidates_next     = 3'b111;
        end
        else if (printable)
        begin
            line_length_next = line_length_reg + 1'b1;
            case (field_stage_reg)
                STAGE_PREFIX:
                begin
                    if ((pos_ext >= CMP_W'(PREFIX_LEN)) ||
                        (rx_byte != PREFIX_TEXT[field_position_reg[1:0]]))
                    begin
                        field_stage_next = STAGE_REJECT;
                    end
                    else if (pos_ext == CMP_W'(PREFIX_LEN - 1))
                    begin
                        field_stage_next    = STAGE_IDENT;
                        field_position_next = '0;
                    end
                    else
                    begin
                        field_position_next = field_position_reg + 1'b1;
                    end
                end
                STAGE_IDENT:
                begin
                    if (rx_byte == CHAR_COLON)
                    begin
                        ident_ok_next       = ident_ok_reg && (pos_ext == ident_len_ext);
                        field_stage_next    = STAGE_COMMAND;
                        field_position_next = '0;
                    end
                    else
                    begin
                        if ((pos_ext >= ident_len_ext) || (rx_byte != ident_char))
                        begin
                            ident_ok_next = 1'b0;
                        end
                        field_position_next = field_position_reg + 1'b1;
                    end
                end
                STAGE_COMMAND:
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                    begin
                        if ((pos_ext >= CMP_W'(WORD_LEN[k])) ||
                            (rx_byte != WORD_TEXT[k][field_position_reg[2:0]]))
                        begin
                            candidates_next[k] = 1'b0;
                        end
                    end
                    field_position_next = field_position_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg    <= '0;
            field_position_reg <= '0;
            field_stage_reg    <= STAGE_PREFIX;
            ident_ok_reg       <= 1'b1;
            candidates_reg     <= 3'b111;
        end
        else if (step_en)
        begin
            line_length_reg    <= line_length_next;
            field_position_reg <= field_position_next;
            field_stage_reg    <= field_stage_next;
            ident_ok_reg       <= ident_ok_next;
            candidates_reg     <= candidates_next;
        end
    end
endmodule

// ===== design/addressed_command_line_parser.sv =====
// a byte is registered in the input register on acceptance; its action, if any,
//   is registered in the result register when the byte is parsed
// throughput: one byte per cycle unless a held action waits for act.ready
// reset: rst_n clears the line state, the config registers and the valid
//   flags of both pipeline registers; no clearing pass is needed
module addressed_command_line_parser #(
    parameter int unsigned LINE_CAPACITY = 64,
    parameter int unsigned IDENT_CHARS   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    clp_rx_if.sink                            rx,
    clp_act_if.source                         act,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [clp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [clp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import clp_pkg::*;

    cfg_t       cfg;

    // input register: one received byte waiting to be parsed
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // result register: one action waiting to be taken
    logic       out_valid_reg, out_valid_next;
    action_t    out_action_reg;

    logic       in_fire;
    logic       advance;
    logic       step_emit;
    action_t    step_action;

    // the held byte is parsed once the result register can take its outcome
    assign advance  = in_valid_reg && (!out_valid_reg || act.ready);
    assign rx.ready = !in_valid_reg || advance;
    assign in_fire  = rx.valid && rx.ready;

    assign in_valid_next  = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance ? step_emit : (out_valid_reg && !act.ready);

    clp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // line state and on-the-fly matching, updated once per parsed byte
    clp_line_step #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .IDENT_CHARS   (IDENT_CHARS)
    ) u_line_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .emit    (step_emit),
        .action  (step_action)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            out_action_reg <= step_action;
        end
    end

    assign act.valid  = out_valid_reg;
    assign act.action = out_action_reg;
endmodule
